@@ rtl/core/kufe_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kufe_pkg - shared definitions for the union-find spanning tree engine
// Field widths, action codes, store constants and the result record.
// ----------------------------------------------------------------------------
package kufe_pkg;

    // Field widths
    localparam int unsigned VERTEX_W = 10;
    localparam int unsigned WEIGHT_W = 32;
    localparam int unsigned TOTAL_W  = 64;
    localparam int unsigned COUNT_W  = 10;
    localparam int unsigned SIZE_W   = 11;

    // Default number of vertex entries in the stores
    localparam int unsigned MAX_VERTICES_DEF = 1024;

    // Register reset value
    localparam logic [VERTEX_W-1:0] VCOUNT_RESET = VERTEX_W'(1023);

    // Component size constants
    localparam logic [SIZE_W-1:0] SIZE_ONE = SIZE_W'(1);
    localparam logic [SIZE_W-1:0] SIZE_SAT = SIZE_W'(2047);

    // Action codes
    localparam logic ACTION_BEGIN = 1'b0;
    localparam logic ACTION_EDGE  = 1'b1;

    // One result record
    typedef struct packed {
        logic               taken;
        logic [TOTAL_W-1:0] weight;
        logic [COUNT_W-1:0] edges;
        logic               bad;
    } result_t;

endpackage

@@ rtl/core/kruskal_union_find_engine.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kruskal_union_find_engine - union-find engine for spanning tree building
// Takes weight-sorted edges, finds both roots with path compression, joins
// sets by size and reports the running tree weight and edge count.
//
//   Channel    Signals                                       Direction
//   command    start, busy, action, edge_weight,             in (busy out)
//              first_vertex, second_vertex
//   result     done, edge_taken, tree_weight, tree_edges,    out
//              bad_vertex
//   config     cfg_valid, cfg_ready, cfg_data                in (ready out)
//
// Each root walk and compression step is one parent memory access. An endpoint
// beyond the limit reports in the cycle after the transfer. Begin sweeps the
// store entries up to the limit back to single-vertex sets. After reset a
// clearing pass over all MAX_VERTICES entries runs with busy high.
// done is high for one cycle; results cannot be held off by the receiver.
// ----------------------------------------------------------------------------
module kruskal_union_find_engine #(
    parameter int unsigned MAX_VERTICES = kufe_pkg::MAX_VERTICES_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic                                 action,
    input  logic signed [kufe_pkg::WEIGHT_W-1:0] edge_weight,
    input  logic [kufe_pkg::VERTEX_W-1:0]        first_vertex,
    input  logic [kufe_pkg::VERTEX_W-1:0]        second_vertex,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [kufe_pkg::VERTEX_W-1:0]        cfg_data,
    output logic                                 done,
    output logic                                 edge_taken,
    output logic signed [kufe_pkg::TOTAL_W-1:0]  tree_weight,
    output logic [kufe_pkg::COUNT_W-1:0]         tree_edges,
    output logic                                 bad_vertex
);

    import kufe_pkg::*;

    localparam int unsigned AW = $clog2(MAX_VERTICES);

    result_t            res;
    logic [AW-1:0]      par_rd_addr;
    logic [AW-1:0]      par_rd_data;
    logic               par_wr_en;
    logic [AW-1:0]      par_wr_addr;
    logic [AW-1:0]      par_wr_data;
    logic [AW-1:0]      size_rd_addr;
    logic [SIZE_W-1:0]  size_rd_data;
    logic               size_wr_en;
    logic [AW-1:0]      size_wr_addr;
    logic [SIZE_W-1:0]  size_wr_data;

    // Register writes are always taken
    assign cfg_ready = 1'b1;

    kufe_ctrl #(
        .MAX_VERTICES (MAX_VERTICES),
        .AW           (AW)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .action        (action),
        .edge_weight   (edge_weight),
        .first_vertex  (first_vertex),
        .second_vertex (second_vertex),
        .cfg_we        (cfg_valid & cfg_ready),
        .cfg_data      (cfg_data),
        .busy          (busy),
        .done          (done),
        .res           (res),
        .par_rd_addr   (par_rd_addr),
        .par_rd_data   (par_rd_data),
        .par_wr_en     (par_wr_en),
        .par_wr_addr   (par_wr_addr),
        .par_wr_data   (par_wr_data),
        .size_rd_addr  (size_rd_addr),
        .size_rd_data  (size_rd_data),
        .size_wr_en    (size_wr_en),
        .size_wr_addr  (size_wr_addr),
        .size_wr_data  (size_wr_data)
    );

    // Parent links
    kufe_ram #(
        .DEPTH (MAX_VERTICES),
        .AW    (AW),
        .DW    (AW)
    ) u_parent_ram (
        .clk     (clk),
        .wr_en   (par_wr_en),
        .wr_addr (par_wr_addr),
        .wr_data (par_wr_data),
        .rd_addr (par_rd_addr),
        .rd_data (par_rd_data)
    );

    // Component sizes
    kufe_ram #(
        .DEPTH (MAX_VERTICES),
        .AW    (AW),
        .DW    (SIZE_W)
    ) u_size_ram (
        .clk     (clk),
        .wr_en   (size_wr_en),
        .wr_addr (size_wr_addr),
        .wr_data (size_wr_data),
        .rd_addr (size_rd_addr),
        .rd_data (size_rd_data)
    );

    // Unpack the result record
    assign edge_taken  = res.taken;
    assign tree_weight = res.weight;
    assign tree_edges  = res.edges;
    assign bad_vertex  = res.bad;

endmodule

@@ rtl/core/kufe_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kufe_ram - single write, single read memory
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module kufe_ram #(
    parameter int unsigned DEPTH = 1024,
    parameter int unsigned AW    = 10,
    parameter int unsigned DW    = 10
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [DW-1:0] wr_data,
    input  logic [AW-1:0] rd_addr,
    output logic [DW-1:0] rd_data
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rd_data_reg;

    // Write and registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/core/kufe_cmp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kufe_cmp - shared compare unit
// Equality and unsigned less-than on one operand pair per cycle.
// ----------------------------------------------------------------------------
module kufe_cmp #(
    parameter int unsigned W = 11
) (
    input  logic [W-1:0] op_a,
    input  logic [W-1:0] op_b,
    output logic         eq,
    output logic         lt
);

    // Compare the selected operands
    assign eq = (op_a == op_b);
    assign lt = (op_a <  op_b);

endmodule

@@ rtl/core/kufe_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kufe_ctrl - union-find sequencer
// Walks root paths, compresses them and joins sets by size through one shared
// compare unit, and sweeps the stores on reset and on begin.
// ----------------------------------------------------------------------------
module kufe_ctrl #(
    parameter int unsigned MAX_VERTICES = kufe_pkg::MAX_VERTICES_DEF,
    parameter int unsigned AW           = $clog2(MAX_VERTICES)
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic                                action,
    input  logic signed [kufe_pkg::WEIGHT_W-1:0] edge_weight,
    input  logic [kufe_pkg::VERTEX_W-1:0]       first_vertex,
    input  logic [kufe_pkg::VERTEX_W-1:0]       second_vertex,
    input  logic                                cfg_we,
    input  logic [kufe_pkg::VERTEX_W-1:0]       cfg_data,
    output logic                                busy,
    output logic                                done,
    output kufe_pkg::result_t                   res,
    output logic [AW-1:0]                       par_rd_addr,
    input  logic [AW-1:0]                       par_rd_data,
    output logic                                par_wr_en,
    output logic [AW-1:0]                       par_wr_addr,
    output logic [AW-1:0]                       par_wr_data,
    output logic [AW-1:0]                       size_rd_addr,
    input  logic [kufe_pkg::SIZE_W-1:0]         size_rd_data,
    output logic                                size_wr_en,
    output logic [AW-1:0]                       size_wr_addr,
    output logic [kufe_pkg::SIZE_W-1:0]         size_wr_data
);

    import kufe_pkg::*;

    localparam int unsigned XW = (AW > VERTEX_W) ? AW : VERTEX_W;
    localparam int unsigned CW = (AW > SIZE_W) ? AW : SIZE_W;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_CLEAR = 8'b0000_0010,
        S_FIND  = 8'b0000_0100,
        S_CHK   = 8'b0000_1000,
        S_COMP  = 8'b0001_0000,
        S_JOIN  = 8'b0010_0000,
        S_SZ_A  = 8'b0100_0000,
        S_SZ_B  = 8'b1000_0000
    } state_t;

    state_t                state_reg,  state_next;
    logic [AW-1:0]         cnt_reg,    cnt_next;
    logic [AW-1:0]         last_reg,   last_next;
    logic                  clr_res_reg, clr_res_next;
    logic [AW-1:0]         vtx_reg,    vtx_next;
    logic [AW-1:0]         root_reg,   root_next;
    logic [AW-1:0]         cur_reg,    cur_next;
    logic [AW-1:0]         second_reg, second_next;
    logic [AW-1:0]         x_reg,      x_next;
    logic [SIZE_W-1:0]     sx_reg,     sx_next;
    logic                  phase_reg,  phase_next;
    logic [WEIGHT_W-1:0]   weight_reg, weight_next;
    logic [TOTAL_W-1:0]    total_reg,  total_next;
    logic [COUNT_W-1:0]    count_reg,  count_next;
    logic [VERTEX_W-1:0]   vcount_reg, vcount_next;
    logic                  done_reg,   done_next;
    result_t               res_reg,    res_next;

    logic [XW-1:0]         vc_x;
    logic [XW-1:0]         max_x;
    logic [XW-1:0]         lim_x;
    logic [XW-1:0]         a_x;
    logic [XW-1:0]         b_x;
    logic [AW-1:0]         lim_aw;
    logic [AW-1:0]         a_aw;
    logic [AW-1:0]         b_aw;
    logic                  bad;

    logic [CW-1:0]         cmp_a;
    logic [CW-1:0]         cmp_b;
    logic                  cmp_eq;
    logic                  cmp_lt;

    logic [AW-1:0]         big_idx;
    logic [AW-1:0]         small_idx;
    logic [SIZE_W:0]       size_sum;
    logic [SIZE_W-1:0]     size_sat;
    logic [TOTAL_W-1:0]    weight_ext;
    logic [TOTAL_W-1:0]    total_sum;
    logic [COUNT_W-1:0]    count_inc;
    logic                  find_done;

    // Clamp the vertex limit and range-check the endpoints
    assign vc_x   = XW'(vcount_reg);
    assign max_x  = XW'(MAX_VERTICES - 1);
    assign lim_x  = (vc_x > max_x) ? max_x : vc_x;
    assign a_x    = XW'(first_vertex);
    assign b_x    = XW'(second_vertex);
    assign lim_aw = lim_x[AW-1:0];
    assign a_aw   = a_x[AW-1:0];
    assign b_aw   = b_x[AW-1:0];
    assign bad    = (a_x > lim_x) || (b_x > lim_x);

    // Select operands for the shared compare unit
    always_comb
    begin
        cmp_a = '0;
        cmp_b = '0;
        case (state_reg)
            S_FIND:
            begin
                cmp_a = CW'(par_rd_data);
                cmp_b = CW'(root_reg);
            end
            S_CHK:
            begin
                cmp_a = CW'(vtx_reg);
                cmp_b = CW'(root_reg);
            end
            S_COMP:
            begin
                cmp_a = CW'(par_rd_data);
                cmp_b = CW'(root_reg);
            end
            S_JOIN:
            begin
                cmp_a = CW'(x_reg);
                cmp_b = CW'(root_reg);
            end
            S_SZ_B:
            begin
                cmp_a = CW'(sx_reg);
                cmp_b = CW'(size_rd_data);
            end
            default:
            begin
                cmp_a = '0;
                cmp_b = '0;
            end
        endcase
    end

    kufe_cmp #(
        .W (CW)
    ) u_cmp (
        .op_a (cmp_a),
        .op_b (cmp_b),
        .eq   (cmp_eq),
        .lt   (cmp_lt)
    );

    // Union by size: the smaller set goes under the larger root
    assign big_idx    = cmp_lt ? root_reg : x_reg;
    assign small_idx  = cmp_lt ? x_reg : root_reg;
    assign size_sum   = {1'b0, sx_reg} + {1'b0, size_rd_data};
    assign size_sat   = size_sum[SIZE_W] ? SIZE_SAT : size_sum[SIZE_W-1:0];
    assign weight_ext = {{(TOTAL_W - WEIGHT_W){weight_reg[WEIGHT_W-1]}}, weight_reg};
    assign total_sum  = total_reg + weight_ext;
    assign count_inc  = count_reg + 1'b1;

    // Sequencer
    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        last_next    = last_reg;
        clr_res_next = clr_res_reg;
        vtx_next     = vtx_reg;
        root_next    = root_reg;
        cur_next     = cur_reg;
        second_next  = second_reg;
        x_next       = x_reg;
        sx_next      = sx_reg;
        phase_next   = phase_reg;
        weight_next  = weight_reg;
        total_next   = total_reg;
        count_next   = count_reg;
        vcount_next  = vcount_reg;
        done_next    = 1'b0;
        res_next     = res_reg;
        par_rd_addr  = '0;
        par_wr_en    = 1'b0;
        par_wr_addr  = '0;
        par_wr_data  = '0;
        size_rd_addr = '0;
        size_wr_en   = 1'b0;
        size_wr_addr = '0;
        size_wr_data = '0;
        find_done    = 1'b0;

        // Take a register write
        if (cfg_we)
        begin
            vcount_next = cfg_data;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (action == ACTION_BEGIN)
                    begin
                        last_next    = lim_aw;
                        cnt_next     = '0;
                        total_next   = '0;
                        count_next   = '0;
                        clr_res_next = 1'b1;
                        state_next   = S_CLEAR;
                    end
                    else if (bad)
                    begin
                        done_next = 1'b1;
                        res_next  = '{taken: 1'b0, weight: total_reg,
                                      edges: count_reg, bad: 1'b1};
                    end
                    else
                    begin
                        vtx_next    = a_aw;
                        root_next   = a_aw;
                        second_next = b_aw;
                        weight_next = edge_weight;
                        phase_next  = 1'b0;
                        par_rd_addr = a_aw;
                        state_next  = S_FIND;
                    end
                end
            end

            // Sweep entries back to single-vertex sets
            S_CLEAR:
            begin
                par_wr_en    = 1'b1;
                par_wr_addr  = cnt_reg;
                par_wr_data  = cnt_reg;
                size_wr_en   = 1'b1;
                size_wr_addr = cnt_reg;
                size_wr_data = SIZE_ONE;
                if (cnt_reg == last_reg)
                begin
                    state_next   = S_IDLE;
                    clr_res_next = 1'b0;
                    if (clr_res_reg)
                    begin
                        done_next = 1'b1;
                        res_next  = '0;
                    end
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end

            // Follow parent links to the root, one read per step
            S_FIND:
            begin
                if (cmp_eq)
                begin
                    state_next = S_CHK;
                end
                else
                begin
                    root_next   = par_rd_data;
                    par_rd_addr = par_rd_data;
                end
            end

            // Start compression unless the vertex is its own root
            S_CHK:
            begin
                if (cmp_eq)
                begin
                    find_done = 1'b1;
                end
                else
                begin
                    cur_next    = vtx_reg;
                    par_rd_addr = vtx_reg;
                    state_next  = S_COMP;
                end
            end

            // Point each node on the path at the root
            S_COMP:
            begin
                par_wr_en   = 1'b1;
                par_wr_addr = cur_reg;
                par_wr_data = root_reg;
                if (cmp_eq)
                begin
                    find_done = 1'b1;
                end
                else
                begin
                    cur_next    = par_rd_data;
                    par_rd_addr = par_rd_data;
                end
            end

            // Same tree: report without a change; else read the first root's size
            S_JOIN:
            begin
                if (cmp_eq)
                begin
                    done_next  = 1'b1;
                    res_next   = '{taken: 1'b0, weight: total_reg,
                                   edges: count_reg, bad: 1'b0};
                    state_next = S_IDLE;
                end
                else
                begin
                    size_rd_addr = x_reg;
                    state_next   = S_SZ_A;
                end
            end

            S_SZ_A:
            begin
                sx_next      = size_rd_data;
                size_rd_addr = root_reg;
                state_next   = S_SZ_B;
            end

            // Join the sets and update the totals
            S_SZ_B:
            begin
                par_wr_en    = 1'b1;
                par_wr_addr  = small_idx;
                par_wr_data  = big_idx;
                size_wr_en   = 1'b1;
                size_wr_addr = big_idx;
                size_wr_data = size_sat;
                total_next   = total_sum;
                count_next   = count_inc;
                done_next    = 1'b1;
                res_next     = '{taken: 1'b1, weight: total_sum,
                                 edges: count_inc, bad: 1'b0};
                state_next   = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Advance from the first endpoint to the second, then to the join
        if (find_done)
        begin
            if (!phase_reg)
            begin
                x_next      = root_reg;
                phase_next  = 1'b1;
                vtx_next    = second_reg;
                root_next   = second_reg;
                par_rd_addr = second_reg;
                state_next  = S_FIND;
            end
            else
            begin
                state_next = S_JOIN;
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            cnt_reg     <= '0;
            last_reg    <= AW'(MAX_VERTICES - 1);
            clr_res_reg <= 1'b0;
            phase_reg   <= 1'b0;
            total_reg   <= '0;
            count_reg   <= '0;
            vcount_reg  <= VCOUNT_RESET;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            last_reg    <= last_next;
            clr_res_reg <= clr_res_next;
            phase_reg   <= phase_next;
            total_reg   <= total_next;
            count_reg   <= count_next;
            vcount_reg  <= vcount_next;
            done_reg    <= done_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        vtx_reg    <= vtx_next;
        root_reg   <= root_next;
        cur_reg    <= cur_next;
        second_reg <= second_next;
        x_reg      <= x_next;
        sx_reg     <= sx_next;
        weight_reg <= weight_next;
        res_reg    <= res_next;
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;
    assign res  = res_reg;

endmodule

@@ rtl/core/kufe_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kufe_checker - port-level checks for the union-find engine
// Watches the command and result ports over time; bound to the top level.
// ----------------------------------------------------------------------------
module kufe_checker (
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic done,
    input logic edge_taken,
    input logic bad_vertex
);

    // A command transfer leads to work or to an immediate result
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy || done))
    else $error("command transfer neither started work nor reported");

    // A result is shown only once the block is free again
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
    else $error("result shown while busy");

    // An ignored edge never joins trees
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && bad_vertex) |-> !edge_taken)
    else $error("edge with a bad vertex reported as taken");

    // Busy rises only after a command transfer
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start))
    else $error("busy rose without a command transfer");

    // A result follows work or a command transfer
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy || start))
    else $error("result without preceding work");

endmodule

bind kruskal_union_find_engine kufe_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .done       (done),
    .edge_taken (edge_taken),
    .bad_vertex (bad_vertex)
);
